### src/uvst_pkg.sv
// ----------------------------------------------------------------------------
// Unique value set table package
// Shared beat and cell control types, command and status codes, and the controller states.
// ----------------------------------------------------------------------------
package uvst_pkg;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam int unsigned VALUE_W = 32;

  typedef struct packed {
    logic [1:0]                command;
    logic signed [VALUE_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic       found;
    logic [3:0] position;
    logic [4:0] entries_used;
    logic [1:0] status;
  } out_beat_t;

  typedef struct packed {
    logic in_use;
    logic cmp_en;
    logic load_new;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXE
  } uvst_state_t;

endpackage

### src/unique_value_set_table_core.sv
// ----------------------------------------------------------------------------
// Unique value set table core
// Ordered set of distinct 32-bit values with lookup, add and remove commands.
// ----------------------------------------------------------------------------
// A command beat is taken at a rising edge where start is high and busy is
// low; the beat carries the command code and the value. The result beat is
// shown on out_data for exactly one cycle, marked by out_strobe, and is
// registered at the end of the command's update state. The receiver cannot
// hold it off. Each command passes through a compare state, in which every
// cell of the row compares its stored value with the key and registers the
// match, and an update state, in which the match is encoded and the row is
// updated. A new command can be taken during the previous one's update
// state. A remove shifts every later cell down by one in the update state.
// Reset empties the table; the stored values themselves are not cleared,
// cells beyond the fill count never report a match.
// ----------------------------------------------------------------------------
module unique_value_set_table_core
  import uvst_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  in_data,
  output logic      out_strobe,
  output out_beat_t out_data
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  uvst_state_t state_r, state_nxt;
  logic [1:0]         cmd_r;
  logic [VALUE_W-1:0] value_r;
  logic [CW-1:0]      occ_r, occ_nxt;
  logic               out_strobe_r;
  out_beat_t          out_data_r, out_data_nxt;

  logic accept;
  logic cmp_en;
  logic exe;

  logic [CAPACITY-1:0] hit_w;
  logic [VALUE_W-1:0]  slot_w [CAPACITY];
  logic                found_w;
  logic [IW-1:0]       pos_w;
  logic                full_w;
  logic                add_do;
  logic                rem_do;
  logic [1:0]          status_w;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_EXE;
      S_EXE:   state_nxt = start ? S_CMP : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy   = 1'b0;
    cmp_en = 1'b0;
    exe    = 1'b0;
    case (state_r)
      S_CMP: begin
        busy   = 1'b1;
        cmp_en = 1'b1;
      end
      S_EXE:   exe = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      occ_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      occ_r        <= occ_nxt;
      out_strobe_r <= exe;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_data.command;
      value_r <= in_data.value;
    end
    if (exe) begin
      out_data_r <= out_data_nxt;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctrl_t         ctrl;
    logic [VALUE_W-1:0] next_slot;

    if (i == CAPACITY - 1) begin : g_last
      assign next_slot = '0;
    end else begin : g_mid
      assign next_slot = slot_w[i+1];
    end

    assign ctrl.in_use   = CW'(i) < occ_r;
    assign ctrl.cmp_en   = cmp_en;
    assign ctrl.load_new = exe && add_do && (CW'(i) == occ_r);
    assign ctrl.shift    = exe && rem_do && (IW'(i) >= pos_w) && (CW'(i + 1) < occ_r);

    uvst_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .key_i       (value_r),
      .next_slot_i (next_slot),
      .slot_o      (slot_w[i]),
      .hit_o       (hit_w[i])
    );
  end

  uvst_encoder #(
    .CAPACITY (CAPACITY),
    .IW       (IW)
  ) u_encoder (
    .hit_i   (hit_w),
    .found_o (found_w),
    .pos_o   (pos_w)
  );

  assign full_w = occ_r == CW'(CAPACITY);
  assign add_do = (cmd_r == CMD_ADD) && !found_w && !full_w;
  assign rem_do = (cmd_r == CMD_REMOVE) && found_w;

  always_comb begin
    case (cmd_r)
      CMD_ADD:    status_w = found_w ? ST_NONE : (full_w ? ST_FULL : ST_DONE);
      CMD_REMOVE: status_w = found_w ? ST_DONE : ST_NONE;
      default:    status_w = found_w ? ST_DONE : ST_NONE;
    endcase
  end

  always_comb begin
    occ_nxt = occ_r;
    if (exe && add_do) begin
      occ_nxt = occ_r + CW'(1);
    end else if (exe && rem_do) begin
      occ_nxt = occ_r - CW'(1);
    end
  end

  always_comb begin
    out_data_nxt.found        = found_w;
    out_data_nxt.position     = 4'(pos_w);
    out_data_nxt.entries_used = 5'(occ_nxt);
    out_data_nxt.status       = status_w;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(CAPACITY))
    else $error("Fill count exceeds the table capacity.");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXE |-> $onehot0(hit_w))
    else $error("More than one cell matched the key.");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 3))
    else $error("Result beat without a command beat three cycles earlier.");

  a_occ_change: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (occ_r != $past(occ_r)) |-> out_strobe)
    else $error("Fill count changed outside a command update.");
`endif

endmodule

### src/uvst_cell.sv
// ----------------------------------------------------------------------------
// Unique value set table cell
// Holds one stored value, registers its match against the search key, and
// loads either a new value or its upper neighbor's value on removal.
// ----------------------------------------------------------------------------
module uvst_cell
  import uvst_pkg::*;
(
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic [VALUE_W-1:0] key_i,
  input  logic [VALUE_W-1:0] next_slot_i,
  output logic [VALUE_W-1:0] slot_o,
  output logic               hit_o
);

  logic [VALUE_W-1:0] slot_r;
  logic               hit_r;

  always_ff @(posedge clk) begin
    if (ctrl.load_new) begin
      slot_r <= key_i;
    end else if (ctrl.shift) begin
      slot_r <= next_slot_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      hit_r <= ctrl.in_use && (slot_r == key_i);
    end
  end

  assign slot_o = slot_r;
  assign hit_o  = hit_r;

endmodule

### src/uvst_encoder.sv
// ----------------------------------------------------------------------------
// Unique value set table match encoder
// Turns the registered match flags of the cell row into a hit flag and the
// index of the matching cell. Stored values are distinct, so at most one
// flag is set.
// ----------------------------------------------------------------------------
module uvst_encoder #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned IW       = 4
) (
  input  logic [CAPACITY-1:0] hit_i,
  output logic                found_o,
  output logic [IW-1:0]       pos_o
);

  always_comb begin
    pos_o = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      pos_o = pos_o | (hit_i[i] ? IW'(i) : '0);
    end
  end

  assign found_o = |hit_i;

endmodule

### sim/unique_value_set_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Unique value set table checker
// Watches the command and result channels, keeps its own copy of the table,
// predicts every result beat at the moment its command beat is taken, and
// compares each result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module unique_value_set_table_checker
  import uvst_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_beat_t  in_data,
  input  logic      out_strobe,
  input  out_beat_t out_data,
  output int        fail_count,
  output int        pending
);

  logic [VALUE_W-1:0] table_vals [CAPACITY];
  int unsigned        table_fill = 0;
  out_beat_t          predicted_results [$];
  int                 mismatches = 0;

  function automatic out_beat_t apply_command(in_beat_t beat);
    out_beat_t   res;
    int unsigned idx;
    bit          hit;
    idx = table_fill;
    hit = 1'b0;
    for (int k = 0; k < table_fill; k++) begin
      if (!hit && table_vals[k] == beat.value) begin
        hit = 1'b1;
        idx = k;
      end
    end
    res.found    = hit;
    res.position = hit ? 4'(idx) : 4'd0;
    case (beat.command)
      CMD_ADD: begin
        if (hit) begin
          res.status = ST_NONE;
        end else if (table_fill >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          table_vals[table_fill] = beat.value;
          table_fill++;
          res.status = ST_DONE;
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          for (int unsigned k = idx; k + 1 < table_fill; k++) begin
            table_vals[k] = table_vals[k+1];
          end
          table_fill--;
          res.status = ST_DONE;
        end else begin
          res.status = ST_NONE;
        end
      end
      default: begin
        res.status = hit ? ST_DONE : ST_NONE;
      end
    endcase
    res.entries_used = 5'(table_fill);
    return res;
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      table_fill = 0;
      predicted_results.delete();
    end else begin
      if (out_strobe) begin
        if (predicted_results.size() == 0) begin
          $error("result beat with nothing expected: %p", out_data);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          if (out_data.found !== want.found) begin
            $error("found mismatch: expected %0d, actual %0d", want.found, out_data.found);
            mismatches++;
          end
          if (out_data.position !== want.position) begin
            $error("position mismatch: expected %0d, actual %0d",
                   want.position, out_data.position);
            mismatches++;
          end
          if (out_data.entries_used !== want.entries_used) begin
            $error("entries_used mismatch: expected %0d, actual %0d",
                   want.entries_used, out_data.entries_used);
            mismatches++;
          end
          if (out_data.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   want.status, out_data.status);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        predicted_results.push_back(apply_command(in_data));
      end
    end
    fail_count <= mismatches;
    pending    <= predicted_results.size();
  end

endmodule

### sim/unique_value_set_table_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Unique value set table testbench
// Drives directed and random lookup, add, remove and spare command beats in bursts
// with random gaps, lets the checker predict and compare every result beat,
// and gives the verdict once all results have arrived.
// ----------------------------------------------------------------------------
module unique_value_set_table_core_tb;
  import uvst_pkg::*;

  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned POOL_N     = 24;
  localparam int          IDLE_LIMIT = 400;
  localparam int          PHASES     = 6;
  localparam int          PHASE_LEN  = 95;

  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef enum int {
    MIX_ADD_HEAVY,
    MIX_REMOVE_HEAVY,
    MIX_BALANCED
  } cmd_mix_t;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_beat_t  in_data = '0;
  logic      busy;
  logic      out_strobe;
  out_beat_t out_data;
  int        fail_count;
  int        pending;
  int        idle_cycles = 0;
  int        burst_left  = 1;

  logic signed [VALUE_W-1:0] value_pool [POOL_N];

  unique_value_set_table_core #(.CAPACITY(CAPACITY)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  unique_value_set_table_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_beat(input logic [1:0] cmd, input logic signed [VALUE_W-1:0] val);
    int gap;
    @(negedge clk);
    start   <= 1'b1;
    in_data <= '{command: cmd, value: val};
    while (busy) @(negedge clk);
    @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 16) : $urandom_range(10, 1);
      gap = $urandom_range(6, 0);
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [1:0] pick_command(cmd_mix_t mix);
    int r;
    int add_w;
    int rem_w;
    r = $urandom_range(99, 0);
    case (mix)
      MIX_ADD_HEAVY:    begin add_w = 55; rem_w = 20; end
      MIX_REMOVE_HEAVY: begin add_w = 20; rem_w = 55; end
      default:          begin add_w = 35; rem_w = 35; end
    endcase
    if (r < add_w) return CMD_ADD;
    if (r < add_w + rem_w) return CMD_REMOVE;
    if (r < 95) return CMD_LOOKUP;
    return CMD_SPARE;
  endfunction

  initial begin
    cmd_mix_t mix;
    logic signed [VALUE_W-1:0] val;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = 32'sh0000_0000;
    value_pool[3] = -32'sd1;
    for (int i = 4; i < POOL_N; i++) value_pool[i] = $urandom;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_beat(CMD_LOOKUP, value_pool[0]);
    send_beat(CMD_ADD, value_pool[0]);
    send_beat(CMD_ADD, value_pool[1]);
    send_beat(CMD_ADD, value_pool[0]);
    send_beat(CMD_SPARE, value_pool[1]);
    send_beat(CMD_SPARE, value_pool[2]);
    send_beat(CMD_REMOVE, value_pool[2]);
    send_beat(CMD_REMOVE, value_pool[0]);
    for (int i = 2; i < 17; i++) send_beat(CMD_ADD, value_pool[i]);
    send_beat(CMD_ADD, value_pool[17]);
    send_beat(CMD_LOOKUP, value_pool[16]);
    send_beat(CMD_REMOVE, value_pool[1]);
    send_beat(CMD_REMOVE, value_pool[16]);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      mix = cmd_mix_t'(ph % 3);
      for (int i = 4 + ph; i < POOL_N; i += 5) value_pool[i] = $urandom;
      for (int n = 0; n < PHASE_LEN; n++) begin
        if ($urandom_range(3, 0) == 0) val = $urandom;
        else val = value_pool[$urandom_range(POOL_N - 1, 0)];
        send_beat(pick_command(mix), val);
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
src/uvst_pkg.sv
src/uvst_cell.sv
src/uvst_encoder.sv
src/unique_value_set_table_core.sv
sim/unique_value_set_table_checker.sv
sim/unique_value_set_table_core_tb.sv
